// ===== hdl/kt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the key table: capacity, field widths, op and status codes.
// Used by kt_cell and key_table_swap_remove; depends on nothing else.
package kt_pkg;

  // Table size and derived widths.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the ports.
  localparam int KEY_W    = 32;
  localparam int OP_W     = 3;
  localparam int SLOT_W   = 7;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 7;

  // Width used to compare a slot against the count.
  localparam int CMP_W    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD        = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE_KEY = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_POS = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef logic [KEY_W-1:0] key_t;

endpackage

// ===== hdl/kt_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the key ring: holds a key and passes it on when the ring rotates.
// Depends on kt_pkg for the key type.
module kt_cell (
  input  logic          clk,
  input  logic          shift,
  input  kt_pkg::key_t  din,
  input  logic          ld,
  input  kt_pkg::key_t  ld_val,
  output kt_pkg::key_t  q
);

  kt_pkg::key_t data_r;
  kt_pkg::key_t data_nxt;

  // On a rotation the cell takes its neighbor's key, or a replacement key.
  always_comb begin
    data_nxt = data_r;
    if (shift) begin
      data_nxt = ld ? ld_val : din;
    end
  end

  // Payload register; it needs no reset.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ===== hdl/key_table_swap_remove.sv =====
`timescale 1ns / 1ps
// Top level of the key table: a rotating ring of kt_cell instances and its sequencer.
// Depends on kt_pkg and kt_cell.

// The keys live in a ring of CAPACITY cells that, during a pass, rotates by one cell a
// cycle past a single comparator at the head; one full revolution brings every key back
// to its place. Add, search and remove take one revolution to scan; a successful remove
// takes a second revolution that writes the last key into the freed position. Clear,
// an invalid remove position and an unknown op code take no revolution. Each item is
// accepted in the idle state and is then reported from the result stage, which waits
// until the output register is free. One item is worked on at a time; the next input
// beat is accepted once the result has moved into the output register.
// After reset the table is empty; no clearing pass is needed.
module key_table_swap_remove (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kt_pkg::OP_W-1:0]       in_op,
  input  logic [kt_pkg::KEY_W-1:0]      in_key,
  input  logic [kt_pkg::SLOT_W-1:0]     in_slot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kt_pkg::STATUS_W-1:0]   out_status,
  output logic                          out_found,
  output logic [kt_pkg::POS_W-1:0]      out_where,
  output logic [kt_pkg::POS_W-1:0]      out_count_now
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [kt_pkg::IDX_W-1:0] IDX_LAST = kt_pkg::IDX_W'(kt_pkg::CAPACITY - 1);
  localparam logic [kt_pkg::CNT_W-1:0] CNT_CAP  = kt_pkg::CNT_W'(kt_pkg::CAPACITY);

  logic [1:0]                       state_r, state_nxt;
  logic [kt_pkg::IDX_W-1:0]         idx_r, idx_nxt;
  logic [kt_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [kt_pkg::OP_W-1:0]          op_r, op_nxt;
  kt_pkg::key_t                     key_r, key_nxt;
  logic                             found_r, found_nxt;
  logic [kt_pkg::IDX_W-1:0]         pos_r, pos_nxt;
  kt_pkg::key_t                     last_r, last_nxt;
  logic [kt_pkg::STATUS_W-1:0]      res_status_r, res_status_nxt;
  logic                             res_found_r, res_found_nxt;
  logic [kt_pkg::POS_W-1:0]         res_where_r, res_where_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [kt_pkg::STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic                             out_found_r, out_found_nxt;
  logic [kt_pkg::POS_W-1:0]         out_where_r, out_where_nxt;
  logic [kt_pkg::POS_W-1:0]         out_count_r, out_count_nxt;

  kt_pkg::key_t                     ring_q [kt_pkg::CAPACITY];
  kt_pkg::key_t                     head;
  logic                             shift;
  logic                             tail_ld;
  kt_pkg::key_t                     tail_val;
  logic                             in_acc;
  logic                             out_free;
  logic [kt_pkg::CNT_W-1:0]         idx_ext;
  logic                             in_range;
  logic                             hit;
  logic                             fnd_all;
  logic [kt_pkg::IDX_W-1:0]         pos_all;
  logic                             slot_bad;

  // Ring of cells: each takes its right neighbor's key; the tail takes the head.
  for (genvar i = 0; i < kt_pkg::CAPACITY; i++) begin : g_ring
    if (i == kt_pkg::CAPACITY - 1) begin : g_tail
      kt_cell u_cell (
        .clk    (clk),
        .shift  (shift),
        .din    (ring_q[0]),
        .ld     (tail_ld),
        .ld_val (tail_val),
        .q      (ring_q[i])
      );
    end else begin : g_body
      kt_cell u_cell (
        .clk    (clk),
        .shift  (shift),
        .din    (ring_q[i+1]),
        .ld     (1'b0),
        .ld_val ('0),
        .q      (ring_q[i])
      );
    end
  end

  assign head     = ring_q[0];
  assign shift    = (state_r == S_SCAN) || (state_r == S_WRITE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign idx_ext  = kt_pkg::CNT_W'(idx_r);
  assign in_range = idx_ext < cnt_r;

  // Head comparator: first match below the count, remove by position excluded.
  assign hit      = (state_r == S_SCAN) && (op_r != kt_pkg::OP_REMOVE_POS) &&
                    in_range && !found_r && (head == key_r);
  assign fnd_all  = found_r || hit;
  assign pos_all  = found_r ? pos_r : idx_r;
  assign slot_bad = (in_slot == '0) ||
                    (kt_pkg::CMP_W'(in_slot) > kt_pkg::CMP_W'(cnt_r));

  // Tail write: an add drops the key into the first free position during the scan;
  // the write pass drops the last key into the freed position.
  always_comb begin
    tail_ld  = 1'b0;
    tail_val = key_r;
    if ((state_r == S_SCAN) && (op_r == kt_pkg::OP_ADD) && !found_r &&
        (idx_ext == cnt_r)) begin
      tail_ld = 1'b1;
    end else if ((state_r == S_WRITE) && (idx_r == pos_r)) begin
      tail_ld  = 1'b1;
      tail_val = last_r;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    found_nxt      = found_r;
    pos_nxt        = pos_r;
    last_nxt       = last_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_where_nxt  = res_where_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_where_nxt  = out_where_r;
    out_count_nxt  = out_count_r;

    if (shift) begin
      idx_nxt = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt         = in_op;
          key_nxt        = in_key;
          found_nxt      = 1'b0;
          pos_nxt        = kt_pkg::IDX_W'(in_slot - 1'b1);
          res_status_nxt = kt_pkg::ST_DONE;
          res_found_nxt  = 1'b0;
          res_where_nxt  = '0;
          priority case (in_op)
            kt_pkg::OP_ADD, kt_pkg::OP_REMOVE_KEY, kt_pkg::OP_SEARCH: begin
              state_nxt = S_SCAN;
            end
            kt_pkg::OP_REMOVE_POS: begin
              if (slot_bad) begin
                res_status_nxt = kt_pkg::ST_MISSING;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            kt_pkg::OP_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
        end
        if ((cnt_r != '0) && (idx_ext == cnt_r - 1'b1)) begin
          last_nxt = head;
        end
        // End of the revolution: every stored key has passed the head.
        if (idx_r == IDX_LAST) begin
          state_nxt = S_DONE;
          priority case (op_r)
            kt_pkg::OP_ADD: begin
              if (fnd_all) begin
                res_status_nxt = kt_pkg::ST_PRESENT;
                res_found_nxt  = 1'b1;
                res_where_nxt  = kt_pkg::POS_W'(kt_pkg::CNT_W'(pos_all) + 1'b1);
              end else if (cnt_r >= CNT_CAP) begin
                res_status_nxt = kt_pkg::ST_FULL;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            kt_pkg::OP_REMOVE_KEY: begin
              if (fnd_all) begin
                res_found_nxt = 1'b1;
                res_where_nxt = kt_pkg::POS_W'(kt_pkg::CNT_W'(pos_all) + 1'b1);
                pos_nxt       = pos_all;
                state_nxt     = S_WRITE;
              end else begin
                res_status_nxt = kt_pkg::ST_MISSING;
              end
            end
            kt_pkg::OP_REMOVE_POS: begin
              state_nxt = S_WRITE;
            end
            default: begin
              if (fnd_all) begin
                res_found_nxt = 1'b1;
                res_where_nxt = kt_pkg::POS_W'(kt_pkg::CNT_W'(pos_all) + 1'b1);
              end else begin
                res_status_nxt = kt_pkg::ST_MISSING;
              end
            end
          endcase
        end
      end

      S_WRITE: begin
        if (idx_r == IDX_LAST) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_where_nxt  = res_where_r;
          out_count_nxt  = kt_pkg::POS_W'(cnt_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    found_r      <= found_nxt;
    pos_r        <= pos_nxt;
    last_r       <= last_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_where_r  <= res_where_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_where_r  <= out_where_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_found     = out_found_r;
  assign out_where     = out_where_r;
  assign out_count_now = out_count_r;

  // The count never exceeds the capacity.
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_CAP)
    else $error("entry count above capacity");

  // The ring is aligned whenever the sequencer is idle or reporting.
  a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) || (state_r == S_DONE)) |-> (idx_r == '0))
    else $error("ring not aligned outside a pass");

  // Only a remove runs the write pass.
  a_write_remove: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |->
      ((op_r == kt_pkg::OP_REMOVE_KEY) || (op_r == kt_pkg::OP_REMOVE_POS)))
    else $error("write pass for an op that removes nothing");

  // A new result beat comes only from the result stage.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result beat without a finished item");

  // A write pass always lowers the count by one.
  a_write_dec: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WRITE) && (idx_r == IDX_LAST)) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("remove did not lower the count");

endmodule
